### rtl/pfps_pkg.sv
// Shared types and constants for the particle frame parser with statistics.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package pfps_pkg;

	localparam int ACC_WIDTH_DEF   = 32;
	localparam int COUNT_WIDTH_DEF = 16;
	localparam int ACC_MAX_W       = 48;
	localparam int CNT_MAX_W       = 32;
	localparam int TOTAL_W         = 32;
	localparam int VALUE_W         = 16;
	localparam int GOOD_W          = 16;
	localparam int POS_W           = 5;
	localparam int BYTE_W          = 8;
	localparam int TDATA_IN_W      = 8;
	localparam int TDATA_OUT_W     = 176;
	localparam int TUSER_OUT_W     = 2;

	localparam logic [BYTE_W-1:0]  START_A   = 8'd66;
	localparam logic [BYTE_W-1:0]  START_B   = 8'd77;
	localparam logic [VALUE_W-1:0] MIN_START = 16'd20000;

	localparam logic [POS_W-1:0] POS_START_A  = 5'd0;
	localparam logic [POS_W-1:0] POS_START_B  = 5'd1;
	localparam logic [POS_W-1:0] POS_FINE_HI  = 5'd6;
	localparam logic [POS_W-1:0] POS_FINE_LO  = 5'd7;
	localparam logic [POS_W-1:0] POS_COARSE_HI = 5'd8;
	localparam logic [POS_W-1:0] POS_COARSE_LO = 5'd9;
	localparam logic [POS_W-1:0] POS_SUM_LAST = 5'd29;
	localparam logic [POS_W-1:0] POS_CHECK_HI = 5'd30;
	localparam logic [POS_W-1:0] POS_LAST     = 5'd31;

	typedef enum logic {
		KIND_BYTE  = 1'b0,
		KIND_CLEAR = 1'b1
	} kind_t;

	typedef struct packed {
		logic               done;
		logic               good;
		logic               bad;
		logic [VALUE_W-1:0] fine;
		logic [VALUE_W-1:0] coarse;
	} frame_res_t;

	typedef struct packed {
		logic [GOOD_W-1:0]  good_frames;
		logic [VALUE_W-1:0] coarse_highest;
		logic [VALUE_W-1:0] coarse_lowest;
		logic [VALUE_W-1:0] fine_highest;
		logic [VALUE_W-1:0] fine_lowest;
		logic [TOTAL_W-1:0] coarse_total;
		logic [TOTAL_W-1:0] fine_total;
	} stats_view_t;

endpackage

`default_nettype wire

### rtl/particle_frame_parser_stats_core.sv
// An accepted item passes the input register, then the result register, to result valid.
// Throughput: one item per cycle while not stalled; a waiting result lets in one more item.
// Every item gives exactly one result item.
// Reset: arst_n clears parser position, statistics and both valid flags at once.
// Top level of the particle frame parser; uses pfps_pkg, pfps_frame_parser, pfps_stats.
`timescale 1ns / 1ps
`default_nettype none

module particle_frame_parser_stats_core import pfps_pkg::*; #(
	parameter int ACC_WIDTH   = ACC_WIDTH_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [TDATA_IN_W-1:0]  s_tdata,   // rx_byte
	input  wire logic [0:0]             s_tuser,   // kind
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// fine_value, coarse_value, fine_total, coarse_total, fine_lowest,
	// fine_highest, coarse_lowest, coarse_highest, good_frames
	output logic [TDATA_OUT_W-1:0]      m_tdata,
	output logic [TUSER_OUT_W-1:0]      m_tuser    // frame_good, frame_bad
);

	logic              valid_s1;
	kind_t             kind_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              advance;
	logic              move;
	logic              is_byte;
	frame_res_t        res_raw;
	frame_res_t        res;
	stats_view_t       view;

	assign advance  = !m_tvalid || m_tready;
	assign move     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;
	assign is_byte  = (kind_s1 == KIND_BYTE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1 <= kind_t'(s_tuser[0]);
			byte_s1 <= s_tdata[BYTE_W-1:0];
		end
	end

	pfps_frame_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (move && is_byte),
		.rx_byte (byte_s1),
		.res     (res_raw)
	);

	always_comb begin
		res = res_raw;
		if (!is_byte) begin
			res = '0;
		end
	end

	pfps_stats #(
		.ACC_WIDTH   (ACC_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_stats (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (move && is_byte),
		.clear  (move && !is_byte),
		.res    (res),
		.view   (view)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			m_tuser <= {res.bad, res.good};
			m_tdata <= {view.good_frames, view.coarse_highest, view.coarse_lowest,
			            view.fine_highest, view.fine_lowest, view.coarse_total,
			            view.fine_total, res.coarse, res.fine};
		end
	end

endmodule

`default_nettype wire

### rtl/pfps_frame_parser.sv
// Byte-level frame parser: header match, running sum, value latches, check word.
// Depends on pfps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfps_frame_parser import pfps_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [BYTE_W-1:0] rx_byte,
	output frame_res_t             res
);

	logic [POS_W-1:0]   pos_q, pos_d;
	logic [VALUE_W-1:0] sum_q, sum_d;
	logic [BYTE_W-1:0]  chk_hi_q, chk_hi_d;
	logic [VALUE_W-1:0] fine_q, fine_d;
	logic [VALUE_W-1:0] coarse_q, coarse_d;
	logic [VALUE_W-1:0] sum_add;
	logic [VALUE_W-1:0] check;
	logic               done;

	assign sum_add = sum_q + VALUE_W'(rx_byte);
	assign check   = {chk_hi_q, rx_byte};
	assign done    = (pos_q == POS_LAST);

	always_comb begin
		res.done   = done;
		res.good   = done && (check == sum_q);
		res.bad    = done && (check != sum_q);
		res.fine   = done ? fine_q : '0;
		res.coarse = done ? coarse_q : '0;
	end

	always_comb begin
		pos_d    = pos_q + POS_W'(1);
		sum_d    = sum_q;
		chk_hi_d = chk_hi_q;
		fine_d   = fine_q;
		coarse_d = coarse_q;
		if (pos_q == POS_START_A) begin
			sum_d = VALUE_W'(rx_byte);
			if (rx_byte != START_A) begin
				pos_d = POS_START_A;
			end
		end else if (pos_q == POS_START_B) begin
			sum_d = sum_add;
			if (rx_byte != START_B) begin
				pos_d = POS_START_A;
			end
		end else if (pos_q <= POS_SUM_LAST) begin
			sum_d = sum_add;
			case (pos_q)
				POS_FINE_HI:   fine_d   = {rx_byte, {BYTE_W{1'b0}}};
				POS_FINE_LO:   fine_d   = {fine_q[VALUE_W-1:BYTE_W], rx_byte};
				POS_COARSE_HI: coarse_d = {rx_byte, {BYTE_W{1'b0}}};
				POS_COARSE_LO: coarse_d = {coarse_q[VALUE_W-1:BYTE_W], rx_byte};
				default: ;
			endcase
		end else if (pos_q == POS_CHECK_HI) begin
			chk_hi_d = rx_byte;
		end else begin
			fine_d   = '0;
			coarse_d = '0;
			pos_d    = POS_START_A;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_START_A;
			sum_q    <= '0;
			chk_hi_q <= '0;
			fine_q   <= '0;
			coarse_q <= '0;
		end else if (step) begin
			pos_q    <= pos_d;
			sum_q    <= sum_d;
			chk_hi_q <= chk_hi_d;
			fine_q   <= fine_d;
			coarse_q <= coarse_d;
		end
	end

endmodule

`default_nettype wire

### rtl/pfps_stats.sv
// Running statistics: saturating totals, min and max, saturating frame count.
// Depends on pfps_pkg; takes frame results from pfps_frame_parser.
`timescale 1ns / 1ps
`default_nettype none

module pfps_stats import pfps_pkg::*; #(
	parameter int ACC_WIDTH   = ACC_WIDTH_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic       clear,
	input  wire frame_res_t res,
	output stats_view_t     view
);

	logic [ACC_WIDTH-1:0]   fine_acc_q, fine_acc_d;
	logic [ACC_WIDTH-1:0]   coarse_acc_q, coarse_acc_d;
	logic [VALUE_W-1:0]     fine_min_q, fine_min_d;
	logic [VALUE_W-1:0]     fine_max_q, fine_max_d;
	logic [VALUE_W-1:0]     coarse_min_q, coarse_min_d;
	logic [VALUE_W-1:0]     coarse_max_q, coarse_max_d;
	logic [COUNT_WIDTH-1:0] count_q, count_d;
	logic [ACC_WIDTH:0]     fine_sum, coarse_sum;
	logic [ACC_MAX_W-1:0]   fine_ext, coarse_ext;
	logic [CNT_MAX_W-1:0]   count_ext;

	assign fine_sum   = {1'b0, fine_acc_q} + (ACC_WIDTH+1)'(res.fine);
	assign coarse_sum = {1'b0, coarse_acc_q} + (ACC_WIDTH+1)'(res.coarse);

	always_comb begin
		fine_acc_d   = fine_acc_q;
		coarse_acc_d = coarse_acc_q;
		fine_min_d   = fine_min_q;
		fine_max_d   = fine_max_q;
		coarse_min_d = coarse_min_q;
		coarse_max_d = coarse_max_q;
		count_d      = count_q;
		if (clear) begin
			fine_acc_d   = '0;
			coarse_acc_d = '0;
			fine_min_d   = MIN_START;
			fine_max_d   = '0;
			coarse_min_d = MIN_START;
			coarse_max_d = '0;
			count_d      = '0;
		end else if (step && res.good) begin
			fine_acc_d   = fine_sum[ACC_WIDTH] ? '1 : fine_sum[ACC_WIDTH-1:0];
			coarse_acc_d = coarse_sum[ACC_WIDTH] ? '1 : coarse_sum[ACC_WIDTH-1:0];
			if (res.fine < fine_min_q) begin
				fine_min_d = res.fine;
			end
			if (res.fine > fine_max_q) begin
				fine_max_d = res.fine;
			end
			if (res.coarse < coarse_min_q) begin
				coarse_min_d = res.coarse;
			end
			if (res.coarse > coarse_max_q) begin
				coarse_max_d = res.coarse;
			end
			if (count_q != {COUNT_WIDTH{1'b1}}) begin
				count_d = count_q + COUNT_WIDTH'(1);
			end
		end
	end

	// clamp the reported figures to their field widths
	assign fine_ext   = ACC_MAX_W'(fine_acc_d);
	assign coarse_ext = ACC_MAX_W'(coarse_acc_d);
	assign count_ext  = CNT_MAX_W'(count_d);

	always_comb begin
		view.fine_total     = (|fine_ext[ACC_MAX_W-1:TOTAL_W]) ? '1 : fine_ext[TOTAL_W-1:0];
		view.coarse_total   = (|coarse_ext[ACC_MAX_W-1:TOTAL_W]) ? '1 :
		                      coarse_ext[TOTAL_W-1:0];
		view.fine_lowest    = fine_min_d;
		view.fine_highest   = fine_max_d;
		view.coarse_lowest  = coarse_min_d;
		view.coarse_highest = coarse_max_d;
		view.good_frames    = (|count_ext[CNT_MAX_W-1:GOOD_W]) ? '1 : count_ext[GOOD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fine_acc_q   <= '0;
			coarse_acc_q <= '0;
			fine_min_q   <= MIN_START;
			fine_max_q   <= '0;
			coarse_min_q <= MIN_START;
			coarse_max_q <= '0;
			count_q      <= '0;
		end else if (step || clear) begin
			fine_acc_q   <= fine_acc_d;
			coarse_acc_q <= coarse_acc_d;
			fine_min_q   <= fine_min_d;
			fine_max_q   <= fine_max_d;
			coarse_min_q <= coarse_min_d;
			coarse_max_q <= coarse_max_d;
			count_q      <= count_d;
		end
	end

endmodule

`default_nettype wire

### rtl/pfps_checker.sv
// Port-level checks on the result stream of the particle frame parser.
// Depends on pfps_pkg; bound to particle_frame_parser_stats_core.
`timescale 1ns / 1ps
`default_nettype none

module pfps_checker import pfps_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [TDATA_OUT_W-1:0] m_tdata,
	input wire logic [TUSER_OUT_W-1:0] m_tuser
);

	// a frame is either good or bad, never both
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("frame flagged good and bad");

	// no completed frame means zero values
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == '0) |-> (m_tdata[31:0] == '0))
		else $error("values without a completed frame");

	// after any good frame the minimum does not exceed the maximum
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[175:160] != '0) |->
		(m_tdata[111:96] <= m_tdata[127:112] && m_tdata[143:128] <= m_tdata[159:144]))
		else $error("min above max");

	// a stalled item holds
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled item changed");

endmodule

bind particle_frame_parser_stats_core pfps_checker u_pfps_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

### dv/tb.sv
// Testbench for particle_frame_parser_stats_core: byte frames, clears, noise and truncation.
// Checks every result item against an in-line model of the parser and its statistics.
// Depends on rtl/pfps_pkg.sv and rtl/particle_frame_parser_stats_core.sv.
`timescale 1ns / 1ps

module tb;
	import pfps_pkg::*;

	localparam int ACC_W = ACC_WIDTH_DEF;
	localparam int CNT_W = COUNT_WIDTH_DEF;
	localparam logic [63:0] ACC_LIMIT = (64'd1 << ACC_W) - 64'd1;
	localparam logic [63:0] CNT_LIMIT = (64'd1 << CNT_W) - 64'd1;
	localparam int RESULT_W = TUSER_OUT_W + TDATA_OUT_W;

	typedef enum {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [TDATA_IN_W-1:0] s_tdata = '0;
	logic [0:0] s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_tdata;
	logic [TUSER_OUT_W-1:0] m_tuser;

	// parser and statistics model
	logic [POS_W-1:0] parse_pos;
	logic [15:0] frame_sum, check_word, fine_hold, coarse_hold;
	logic [63:0] fine_sum, coarse_sum, frame_cnt;
	logic [15:0] fine_lo, fine_hi, coarse_lo, coarse_hi;

	logic [RESULT_W-1:0] predicted_readouts[$];
	logic [RESULT_W-1:0] readout_want, readout_got;

	int err_count = 0;
	int items_sent = 0;
	int result_idx = 0;
	int burst_left = 0;
	int gap_max = 0;
	int ready_pct = 100;
	int phase_cnt = 0;
	rx_mode_t rx_mode = RX_ALWAYS;

	particle_frame_parser_stats_core #(
		.ACC_WIDTH(ACC_W),
		.COUNT_WIDTH(CNT_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	always @(posedge clk) begin
		phase_cnt <= phase_cnt + 1;
		case (rx_mode)
			RX_ALWAYS: m_tready <= 1'b1;
			RX_RANDOM: m_tready <= ($urandom_range(0, 99) < ready_pct);
			default: m_tready <= ((phase_cnt % 7) > 2);
		endcase
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at result %0d: %s", result_idx, msg);
		err_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (predicted_readouts.size() == 0) begin
				report_mismatch("result with nothing pending");
			end else begin
				readout_want = predicted_readouts.pop_front();
				readout_got = {m_tuser, m_tdata};
				check_field("fine_value", readout_got[15:0], readout_want[15:0]);
				check_field("coarse_value", readout_got[31:16], readout_want[31:16]);
				check_field("fine_total", readout_got[63:32], readout_want[63:32]);
				check_field("coarse_total", readout_got[95:64], readout_want[95:64]);
				check_field("fine_lowest", readout_got[111:96], readout_want[111:96]);
				check_field("fine_highest", readout_got[127:112], readout_want[127:112]);
				check_field("coarse_lowest", readout_got[143:128], readout_want[143:128]);
				check_field("coarse_highest", readout_got[159:144],
					readout_want[159:144]);
				check_field("good_frames", readout_got[175:160], readout_want[175:160]);
				check_field("frame_good", readout_got[176], readout_want[176]);
				check_field("frame_bad", readout_got[177], readout_want[177]);
			end
			result_idx++;
		end
	end

	task automatic clear_stats_model();
		fine_sum = '0;
		coarse_sum = '0;
		frame_cnt = '0;
		fine_lo = MIN_START;
		fine_hi = '0;
		coarse_lo = MIN_START;
		coarse_hi = '0;
	endtask

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] limit);
		logic [63:0] s;
		s = a + b;
		return (s > limit) ? limit : s;
	endfunction

	task automatic track_parser(input kind_t k, input logic [7:0] b);
		logic [POS_W-1:0] nxt;
		logic good, bad;
		logic [15:0] fv, cv, chk;
		logic [31:0] ftot, ctot;
		logic [15:0] cnt;
		good = 1'b0;
		bad = 1'b0;
		fv = '0;
		cv = '0;
		if (k == KIND_CLEAR) begin
			clear_stats_model();
		end else begin
			nxt = parse_pos + 1'b1;
			if (parse_pos == POS_START_A) begin
				if (b != START_A)
					nxt = POS_START_A;
				frame_sum = {8'h00, b};
			end else if (parse_pos == POS_START_B) begin
				if (b != START_B)
					nxt = POS_START_A;
				frame_sum = frame_sum + b;
			end else if (parse_pos <= POS_SUM_LAST) begin
				frame_sum = frame_sum + b;
				case (parse_pos)
					POS_FINE_HI: fine_hold = {b, 8'h00};
					POS_FINE_LO: fine_hold[7:0] = b;
					POS_COARSE_HI: coarse_hold = {b, 8'h00};
					POS_COARSE_LO: coarse_hold[7:0] = b;
					default: ;
				endcase
			end else if (parse_pos == POS_CHECK_HI) begin
				check_word = {b, 8'h00};
			end else begin
				chk = {check_word[15:8], b};
				check_word = chk;
				fv = fine_hold;
				cv = coarse_hold;
				if (chk == frame_sum) begin
					good = 1'b1;
					fine_sum = sat_add(fine_sum, fv, ACC_LIMIT);
					coarse_sum = sat_add(coarse_sum, cv, ACC_LIMIT);
					if (fv < fine_lo) fine_lo = fv;
					if (fv > fine_hi) fine_hi = fv;
					if (cv < coarse_lo) coarse_lo = cv;
					if (cv > coarse_hi) coarse_hi = cv;
					frame_cnt = sat_add(frame_cnt, 64'd1, CNT_LIMIT);
				end else begin
					bad = 1'b1;
				end
				fine_hold = '0;
				coarse_hold = '0;
				nxt = POS_START_A;
			end
			parse_pos = nxt;
		end
		ftot = (fine_sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : fine_sum[31:0];
		ctot = (coarse_sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : coarse_sum[31:0];
		cnt = (frame_cnt > 64'hFFFF) ? 16'hFFFF : frame_cnt[15:0];
		predicted_readouts.push_back({bad, good, cnt, coarse_hi, coarse_lo, fine_hi,
			fine_lo, ctot, ftot, cv, fv});
	endtask

	task automatic send_item(input kind_t k, input logic [7:0] b);
		int gap;
		if (gap_max > 0 && burst_left == 0) begin
			gap = $urandom_range(1, gap_max);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0)
			burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= k;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		track_parser(k, b);
	endtask

	function automatic logic [15:0] pick_level();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(19999, 20001));
			3: return 16'($urandom_range(20002, 65535));
			4: return 16'($urandom);
			default: return 16'($urandom_range(0, 1000));
		endcase
	endfunction

	task automatic send_frame(input logic [15:0] fine, input logic [15:0] coarse,
			input bit bad_check, input int cut, input bit with_clears);
		logic [7:0] fb[32];
		logic [15:0] sum;
		int i;
		sum = '0;
		for (i = 0; i < 30; i++) begin
			fb[i] = 8'($urandom_range(0, 255));
			case (i)
				0: fb[i] = START_A;
				1: fb[i] = START_B;
				6: fb[i] = fine[15:8];
				7: fb[i] = fine[7:0];
				8: fb[i] = coarse[15:8];
				9: fb[i] = coarse[7:0];
				default: ;
			endcase
			sum = sum + fb[i];
		end
		if (bad_check)
			sum = sum ^ 16'($urandom_range(1, 65535));
		fb[30] = sum[15:8];
		fb[31] = sum[7:0];
		for (i = 0; i < cut; i++) begin
			if (with_clears && $urandom_range(0, 60) == 0)
				send_item(KIND_CLEAR, 8'($urandom));
			send_item(KIND_BYTE, fb[i]);
		end
	endtask

	task automatic resync_parser();
		while (parse_pos != POS_START_A)
			send_item(KIND_BYTE, 8'h00);
	endtask

	task automatic test_header_sync();
		rx_mode = RX_ALWAYS;
		gap_max = 0;
		send_item(KIND_BYTE, 8'h00);
		send_item(KIND_BYTE, 8'hFF);
		send_item(KIND_BYTE, START_B);
		send_item(KIND_BYTE, START_A);
		send_item(KIND_BYTE, START_A);
		send_item(KIND_BYTE, START_B);
		send_item(KIND_BYTE, START_A);
		send_item(KIND_BYTE, 8'h00);
		send_frame(16'd25, 16'd40, 1'b0, 32, 1'b0);
	endtask

	task automatic test_frame_extremes();
		rx_mode = RX_PERIODIC;
		gap_max = 3;
		send_frame(16'hFFFF, 16'h0000, 1'b0, 32, 1'b0);
		send_frame(16'h0000, 16'hFFFF, 1'b0, 32, 1'b0);
		send_frame(16'd500, 16'd700, 1'b1, 32, 1'b0);
		send_item(KIND_CLEAR, 8'hFF);
		// values above the min start leave the min alone
		send_frame(16'd20001, 16'd30000, 1'b0, 32, 1'b0);
		send_frame(16'd12, 16'd34, 1'b0, 12, 1'b0);
		send_item(KIND_CLEAR, 8'h00);
		resync_parser();
		send_frame(16'd19999, 16'd20000, 1'b0, 32, 1'b0);
	endtask

	task automatic test_random_streams();
		int pick, n, chunk_end;
		while (items_sent < 1250) begin
			case ($urandom_range(0, 3))
				0: begin rx_mode = RX_ALWAYS; gap_max = 0; end
				1: begin rx_mode = RX_RANDOM; ready_pct = $urandom_range(30, 90);
					gap_max = $urandom_range(1, 6); end
				2: begin rx_mode = RX_PERIODIC; gap_max = $urandom_range(0, 4); end
				default: begin rx_mode = RX_RANDOM; ready_pct = 60; gap_max = 0; end
			endcase
			chunk_end = items_sent + 150;
			while (items_sent < chunk_end && items_sent < 1250) begin
				pick = $urandom_range(0, 99);
				if (pick < 68) begin
					send_frame(pick_level(), pick_level(), 1'b0, 32, 1'b1);
				end else if (pick < 80) begin
					send_frame(pick_level(), pick_level(), 1'b1, 32, 1'b1);
				end else if (pick < 88) begin
					send_frame(pick_level(), pick_level(), 1'b0, $urandom_range(1, 31), 1'b0);
					resync_parser();
				end else if (pick < 95) begin
					n = $urandom_range(1, 10);
					repeat (n) begin
						if ($urandom_range(0, 3) == 0)
							send_item(KIND_BYTE, $urandom_range(0, 1) ? START_A : START_B);
						else
							send_item(KIND_BYTE, 8'($urandom));
					end
					resync_parser();
				end else begin
					send_item(KIND_CLEAR, 8'($urandom));
				end
			end
		end
	endtask

	initial begin
		parse_pos = POS_START_A;
		frame_sum = '0;
		check_word = '0;
		fine_hold = '0;
		coarse_hold = '0;
		clear_stats_model();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_header_sync();
		test_frame_extremes();
		test_random_streams();
		s_tvalid <= 1'b0;
		rx_mode = RX_RANDOM;
		ready_pct = 70;
		while (predicted_readouts.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
